// ===== rtl/pidm_pkg.sv =====
// ============================================================================
// pidm_pkg
// Shared types and constants for the PID position motor drive.
// ============================================================================
package pidm_pkg;

    // Fixed field widths
    localparam int POS_W   = 32;
    localparam int ERR_W   = POS_W + 1;
    localparam int GAIN_W  = 32;
    localparam int DT_W    = 16;
    localparam int LIMIT_W = 8;
    localparam int DRIVE_W = 9;
    localparam int FRAC_W  = 16;

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam int REG_GAIN_INTEG_IDX = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG = 3'(REG_GAIN_INTEG_IDX);
    localparam logic [CFG_ADDR_W-1:0] REG_PWM_LIMIT  = 3'd4;

    localparam logic [LIMIT_W-1:0] PWM_LIMIT_RST = 8'd255;

    // Shared unit step counts
    localparam int MUL_STEPS = GAIN_W;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = 7;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } pidm_op_t;

    typedef struct packed {
        logic     start;
        pidm_op_t op;
    } pidm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pidm_stat_t;

endpackage

// ===== rtl/pidm_muldiv.sv =====
// ============================================================================
// pidm_muldiv
// Shared shift-add multiplier and restoring divider on unsigned magnitudes.
// ============================================================================
module pidm_muldiv
    import pidm_pkg::*;
#(
    parameter int PROD_W = 80
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pidm_req_t         req,
    input  logic [PROD_W-1:0] opa,     // multiplicand or dividend
    input  logic [GAIN_W-1:0] opb,     // multiplier, or divisor in low bits
    output pidm_stat_t        stat,
    output logic [PROD_W-1:0] result   // product or quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    pidm_op_t          op_reg, op_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [GAIN_W-1:0] mplier_reg, mplier_next;
    logic [DT_W-1:0]   rem_reg, rem_next;

    logic [DT_W:0]     trial;
    logic [DT_W:0]     diff;
    logic              fits;

    // Restoring division step
    assign trial = {rem_reg, acc_reg[DIV_STEPS-1]};
    assign fits  = trial >= {1'b0, mplier_reg[DT_W-1:0]};
    assign diff  = trial - {1'b0, mplier_reg[DT_W-1:0]};

    // Next state
    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        op_next     = op_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            op_next     = req.op;
            mplier_next = opb;
            rem_next    = '0;
            unique case (req.op)
                OP_MUL: begin
                    count_next = CNT_W'(MUL_STEPS);
                    acc_next   = '0;
                    mcand_next = opa;
                end
                OP_DIV: begin
                    count_next = CNT_W'(DIV_STEPS);
                    acc_next   = opa;
                end
                default: begin
                    count_next = CNT_W'(MUL_STEPS);
                end
            endcase
        end else if (busy_reg) begin
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            unique case (op_reg)
                OP_MUL: begin
                    if (mplier_reg[0]) begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[GAIN_W-1:1]};
                end
                OP_DIV: begin
                    acc_next = '0;
                    acc_next[DIV_STEPS-1:0] = {acc_reg[DIV_STEPS-2:0], fits};
                    rem_next = fits ? diff[DT_W-1:0] : trial[DT_W-1:0];
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            op_reg    <= OP_MUL;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            op_reg    <= op_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

// ===== rtl/pid_position_motor_drive.sv =====
// ============================================================================
// pid_position_motor_drive
// PID position loop with clamped signed drive and H-bridge outputs.
// ============================================================================
// Each sample passes acceptance, then the proportional product, the derivative
// product, the rate quotient and the integral product on the single shared
// multiply/divide unit (32 shift-add steps per product, 64 restoring-division
// steps for the quotient, each after a start state), then magnitude and the
// output load.
// s_tready is low while a sample is in work. The result sits in an output
// register, so a new sample is taken while the last result waits for
// m_tready; a result stalls the sequencer only when a second one is ready.
// Configuration must be written only while the block is idle; the block does not enforce this.
module pid_position_motor_drive
    import pidm_pkg::*;
#(
    parameter int INTEG_WIDTH = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] position, [47:32] elapsed_us
    // Results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [8:0] drive, [9] dir_a, [10] dir_b,
                                             // [18:11] pwm_duty, [19] clamped, rest 0
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PROD_W = INTEG_WIDTH + GAIN_W;
    localparam int ACC_W  = INTEG_WIDTH + GAIN_W + 2;
    localparam int IVAL_W = ACC_W - FRAC_W;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_P_GO  = 11'b00000000010,
        ST_P_RUN = 11'b00000000100,
        ST_D_GO  = 11'b00000001000,
        ST_D_RUN = 11'b00000010000,
        ST_V_GO  = 11'b00000100000,
        ST_V_RUN = 11'b00001000000,
        ST_I_GO  = 11'b00010000000,
        ST_I_RUN = 11'b00100000000,
        ST_ABS   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [POS_W-1:0]   target_reg;
    logic [GAIN_W-1:0]  kp_reg, kd_reg, ki_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Loop state
    logic [POS_W-1:0]       last_pos_reg;
    logic [INTEG_WIDTH-1:0] esum_reg, esum_next;
    logic                   have_last_reg;

    // Per-sample working registers
    logic [ERR_W-1:0] err_reg, delta_reg;
    logic [DT_W-1:0]  dt_reg;
    logic [ACC_W-1:0] sum_reg, sum_next;
    logic             neg_reg, neg_next;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Shared unit
    pidm_req_t         req;
    pidm_stat_t        stat;
    logic [PROD_W-1:0] opa;
    logic [GAIN_W-1:0] opb;
    logic [PROD_W-1:0] unit_res;

    logic [POS_W-1:0] in_pos;
    logic [DT_W-1:0]  in_dt;
    logic             accept;
    logic             out_free;

    logic [ERR_W-1:0]       err_c, delta_c;
    logic [INTEG_WIDTH:0]   esum_add;
    logic [ERR_W-1:0]       err_mag, delta_mag;
    logic [INTEG_WIDTH-1:0] esum_mag;
    logic [GAIN_W-1:0]      kp_mag, kd_mag, ki_mag;
    logic                   term_neg;
    logic [ACC_W-1:0]       term_mag, term;

    logic [IVAL_W-1:0]  ival;
    logic               clip;
    logic [LIMIT_W-1:0] mag8;
    logic [DRIVE_W-1:0] drive;

    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_dt    = s_tdata[POS_W+DT_W-1:POS_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Error, position change and saturating integral on acceptance
    assign err_c   = {target_reg[POS_W-1], target_reg} - {in_pos[POS_W-1], in_pos};
    assign delta_c = have_last_reg ?
                     ({in_pos[POS_W-1], in_pos} - {last_pos_reg[POS_W-1], last_pos_reg}) : '0;
    assign esum_add = {esum_reg[INTEG_WIDTH-1], esum_reg}
                    + {{(INTEG_WIDTH+1-ERR_W){err_c[ERR_W-1]}}, err_c};

    always_comb begin
        esum_next = esum_add[INTEG_WIDTH-1:0];
        if (esum_add[INTEG_WIDTH] != esum_add[INTEG_WIDTH-1]) begin
            esum_next = esum_add[INTEG_WIDTH] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                              : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
        end
    end

    // Operand magnitudes
    assign err_mag   = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
    assign delta_mag = delta_reg[ERR_W-1] ? (~delta_reg + 1'b1) : delta_reg;
    assign esum_mag  = esum_reg[INTEG_WIDTH-1] ? (~esum_reg + 1'b1) : esum_reg;
    assign kp_mag    = kp_reg[GAIN_W-1] ? (~kp_reg + 1'b1) : kp_reg;
    assign kd_mag    = kd_reg[GAIN_W-1] ? (~kd_reg + 1'b1) : kd_reg;
    assign ki_mag    = ki_reg[GAIN_W-1] ? (~ki_reg + 1'b1) : ki_reg;

    // Unit requests and term sign by step
    always_comb begin
        req.start = 1'b0;
        req.op    = OP_MUL;
        opa       = '0;
        opb       = '0;
        term_neg  = 1'b0;
        unique case (state_reg)
            ST_P_GO: begin
                req.start = 1'b1;
                opa       = PROD_W'(err_mag);
                opb       = kp_mag;
            end
            ST_D_GO: begin
                req.start = 1'b1;
                opa       = PROD_W'(delta_mag);
                opb       = kd_mag;
            end
            ST_V_GO: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                opa       = unit_res;
                opb       = GAIN_W'(dt_reg);
            end
            ST_I_GO: begin
                req.start = 1'b1;
                opa       = PROD_W'(esum_mag);
                opb       = ki_mag;
            end
            ST_P_RUN: term_neg = err_reg[ERR_W-1] ^ kp_reg[GAIN_W-1];
            ST_V_RUN: term_neg = delta_reg[ERR_W-1] ^ kd_reg[GAIN_W-1];
            ST_I_RUN: term_neg = esum_reg[INTEG_WIDTH-1] ^ ki_reg[GAIN_W-1];
            default: begin
                term_neg = 1'b0;
            end
        endcase
    end

    assign term_mag = ACC_W'(unit_res);
    assign term     = term_neg ? (~term_mag + 1'b1) : term_mag;

    // Truncate, clamp and pack
    assign ival  = sum_reg[ACC_W-1:FRAC_W];
    assign clip  = ival > IVAL_W'(limit_reg);
    assign mag8  = clip ? limit_reg : ival[LIMIT_W-1:0];
    assign drive = neg_reg ? (~{1'b0, mag8} + 1'b1) : {1'b0, mag8};

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[DRIVE_W-1:0]                 = drive;
        m_tdata_next[DRIVE_W]                     = drive[DRIVE_W-1];
        m_tdata_next[DRIVE_W+1]                   = !drive[DRIVE_W-1];
        m_tdata_next[DRIVE_W+2+LIMIT_W-1:DRIVE_W+2] = mag8;
        m_tdata_next[DRIVE_W+2+LIMIT_W]           = clip;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_P_GO;
            ST_P_GO:  state_next = ST_P_RUN;
            ST_P_RUN: begin
                if (stat.done) begin
                    sum_next   = term;
                    state_next = ST_D_GO;
                end
            end
            ST_D_GO:  state_next = ST_D_RUN;
            ST_D_RUN: if (stat.done) state_next = ST_V_GO;
            ST_V_GO:  state_next = ST_V_RUN;
            ST_V_RUN: begin
                if (stat.done) begin
                    sum_next   = sum_reg + term;
                    state_next = ST_I_GO;
                end
            end
            ST_I_GO:  state_next = ST_I_RUN;
            ST_I_RUN: begin
                if (stat.done) begin
                    sum_next   = sum_reg + term;
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                neg_next   = sum_reg[ACC_W-1];
                sum_next   = sum_reg[ACC_W-1] ? (~sum_reg + 1'b1) : sum_reg;
                state_next = ST_OUT;
            end
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    pidm_muldiv #(
        .PROD_W (PROD_W)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opa     (opa),
        .opb     (opb),
        .stat    (stat),
        .result  (unit_res)
    );

    // Configuration and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= '0;
            kp_reg        <= '0;
            kd_reg        <= '0;
            ki_reg        <= '0;
            limit_reg     <= PWM_LIMIT_RST;
            last_pos_reg  <= '0;
            esum_reg      <= '0;
            have_last_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_TARGET:     target_reg <= cfg_wdata[POS_W-1:0];
                    REG_GAIN_PROP:  kp_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_DERIV: kd_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_INTEG: ki_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_PWM_LIMIT:  limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                last_pos_reg  <= in_pos;
                esum_reg      <= esum_next;
                have_last_reg <= 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        neg_reg <= neg_next;
        if (accept) begin
            err_reg   <= err_c;
            delta_reg <= delta_c;
            dt_reg    <= (in_dt == '0) ? DT_W'(1) : in_dt;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // Unit never restarted mid-operation
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !stat.busy)
        else $error("shared unit started while busy");

    // Accepted sample is remembered for the next derivative
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> have_last_reg)
        else $error("previous sample flag not set after transfer");

    // Integral moves only on an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(esum_reg))
        else $error("integral changed without an input transfer");

    // Result shows up only from the output step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result valid raised outside output step");

    // Direction lines are complementary on every result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DRIVE_W] != m_tdata[DRIVE_W+1]))
        else $error("bridge direction lines not complementary");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: PID position motor drive testbench
// Streams encoder samples into the drive, predicts every drive result in wide
// signed arithmetic and checks each result transfer field by field. Register
// settings change between runs while the block is idle; both stream sides
// idle at random and the result side holds off once to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import pidm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int INTEG_W      = 48;
    localparam int RANDOM_ITEMS = 1925;
    localparam int FINAL_RUN    = 150;    // last run, no idling on either side
    localparam int HOLD_AFTER   = 400;    // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_CAP   = 40;

    typedef logic signed [127:0] wide_t;

    localparam wide_t ACC_MAX = (wide_t'(1) << (INTEG_W - 1)) - wide_t'(1);
    localparam wide_t ACC_MIN = -ACC_MAX - wide_t'(1);

    // Result fields from bit 0 up: drive, dir_a, dir_b, pwm_duty, clamped
    typedef struct packed {
        logic       clamped;
        logic [7:0] pwm_duty;
        logic       dir_b;
        logic       dir_a;
        logic [8:0] drive;
    } drive_t;

    localparam int DRIVE_BITS = $bits(drive_t);

    // ------------------------------------------------------------------------
    // Drive predictor and result checker
    // ------------------------------------------------------------------------
    class drive_tracker;
        logic signed [31:0]        target, kp, kd, ki;
        logic [7:0]                limit;
        logic signed [31:0]        last_pos;
        logic signed [INTEG_W-1:0] err_acc;
        bit                        have_last;
        drive_t                    pending_drives[$];
        int unsigned               mismatches, checked, clamped_seen;

        function new();
            target    = '0;
            kp        = '0;
            kd        = '0;
            ki        = '0;
            limit     = PWM_LIMIT_RST;
            last_pos  = '0;
            err_acc   = '0;
            have_last = 1'b0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_TARGET:     target = val;
                REG_GAIN_PROP:  kp     = val;
                REG_GAIN_DERIV: kd     = val;
                REG_GAIN_INTEG: ki     = val;
                REG_PWM_LIMIT:  limit  = val[7:0];
                default: ;
            endcase
        endfunction

        // Accepted sample: advance the loop state and queue the expected drive
        function void note_sample(logic [31:0] pos, logic [15:0] dt);
            wide_t      pos_w, err_w, acc_w, step_w, span_w, rate_w;
            wide_t      sum_w, mag_w, whole_w;
            logic       neg, clip;
            logic [7:0] duty;
            drive_t     want;
            pos_w = wide_t'($signed(pos));
            err_w = wide_t'(target) - pos_w;

            // integral saturates at the accumulator's signed bounds
            acc_w = wide_t'(err_acc) + err_w;
            if (acc_w > ACC_MAX)
                acc_w = ACC_MAX;
            else if (acc_w < ACC_MIN)
                acc_w = ACC_MIN;
            err_acc = acc_w[INTEG_W-1:0];

            // no position change on the first sample; zero elapsed counts as one
            if (have_last)
                step_w = pos_w - wide_t'(last_pos);
            else
                step_w = '0;
            span_w = (dt == '0) ? wide_t'(1) : wide_t'({1'b0, dt});
            rate_w = (wide_t'(kd) * step_w) / span_w;

            sum_w   = wide_t'(kp) * err_w + rate_w + wide_t'(ki) * acc_w;
            neg     = (sum_w < 0);
            mag_w   = neg ? -sum_w : sum_w;
            whole_w = mag_w >> FRAC_W;
            clip    = (whole_w > wide_t'({1'b0, limit}));
            duty    = clip ? limit : whole_w[7:0];

            want.drive = {1'b0, duty};
            if (neg)
                want.drive = -want.drive;
            want.dir_a    = neg && (duty != '0);
            want.dir_b    = !want.dir_a;
            want.pwm_duty = duty;
            want.clamped  = clip;
            pending_drives.push_back(want);

            last_pos  = pos;
            have_last = 1'b1;
        endfunction

        function void report(string field, int exp_val, int act_val);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_val, act_val);
        endfunction

        function void check_drive(logic [M_TDATA_W-1:0] tdata);
            drive_t got, want;
            got = drive_t'(tdata[DRIVE_BITS-1:0]);
            checked++;
            if (pending_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result transfer with no sample outstanding, expected none, actual %h",
                             $time, tdata);
                return;
            end
            want = pending_drives.pop_front();
            if (want.clamped)
                clamped_seen++;
            if (got.drive !== want.drive)
                report("drive", int'($signed(want.drive)), int'($signed(got.drive)));
            if (got.dir_a !== want.dir_a)
                report("dir_a", int'(want.dir_a), int'(got.dir_a));
            if (got.dir_b !== want.dir_b)
                report("dir_b", int'(want.dir_b), int'(got.dir_b));
            if (got.pwm_duty !== want.pwm_duty)
                report("pwm_duty", int'(want.pwm_duty), int'(got.pwm_duty));
            if (got.clamped !== want.clamped)
                report("clamped", int'(want.clamped), int'(got.clamped));
            if (tdata[M_TDATA_W-1:DRIVE_BITS] !== '0)
                report("padding", 0, int'(tdata[M_TDATA_W-1:DRIVE_BITS]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and shared state
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    drive_tracker tracker = new();
    bit           idle_on = 1'b1;
    bit           hold_done = 1'b0;
    int unsigned  samples_sent, settings_loaded;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pid_position_motor_drive #(.INTEG_WIDTH(INTEG_W)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Result side: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!hold_done && tracker.checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall     = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_drive(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks; each is entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [31:0] pos, input logic [15:0] dt);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tdata  <= {dt, pos};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_sample(pos, dt);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        tracker.set_reg(idx, val);
    endtask

    // All registers, then a write to an unmapped index that must be ignored
    task automatic load_settings(input logic [31:0] target, input logic [31:0] kp,
                                 input logic [31:0] kd, input logic [31:0] ki,
                                 input logic [7:0] lim);
        logic [CFG_ADDR_W-1:0] spare;
        spare = CFG_ADDR_W'($urandom_range(int'(REG_PWM_LIMIT) + 1,
                                           (1 << CFG_ADDR_W) - 1));
        write_reg(REG_TARGET, target);
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_PWM_LIMIT, {24'($urandom), lim});
        write_reg(spare, $urandom);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic wait_drained();
        while (tracker.pending_drives.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Register setting for one random run; returns the target for centering
    task automatic load_random_settings(output logic [31:0] target);
        logic [31:0] kp, kd, ki;
        logic [7:0]  lim;
        case ($urandom_range(0, 3))
            0, 1: begin
                // gains that keep the drive mostly inside the limit
                target = $urandom;
                kp     = 32'($urandom_range(0, 8 << FRAC_W)) - 32'(4 << FRAC_W);
                kd     = 32'($urandom_range(0, 8 << FRAC_W)) - 32'(4 << FRAC_W);
                ki     = 32'($urandom_range(0, 128)) - 32'd64;
                lim    = 8'($urandom_range(0, 255));
            end
            2: begin
                target = extreme_word();
                kp     = extreme_word();
                kd     = extreme_word();
                ki     = extreme_word();
                case ($urandom_range(0, 2))
                    0:       lim = '0;
                    1:       lim = '1;
                    default: lim = 8'd1;
                endcase
            end
            default: begin
                target = $urandom;
                kp     = $urandom;
                kd     = $urandom;
                ki     = $urandom;
                lim    = 8'($urandom);
            end
        endcase
        load_settings(target, kp, kd, ki, lim);
    endtask

    // Mostly a walk around the target, with jumps, extremes and odd sample times
    task automatic send_random_run(input int unsigned count, input logic [31:0] center);
        logic [31:0] pos;
        logic [15:0] dt;
        int unsigned pick;
        pos = center + 32'($urandom_range(0, 200)) - 32'd100;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pos = pos + 32'($urandom_range(0, 1000)) - 32'd500;
            else if (pick < 78)
                pos = center + 32'($urandom_range(0, 64)) - 32'd32;
            else if (pick < 92)
                pos = $urandom;
            else
                pos = extreme_word();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                dt = 16'($urandom_range(1, 2000));
            else if (pick < 85)
                dt = 16'($urandom_range(0, 65535));
            else if (pick < 90)
                dt = '0;
            else if (pick < 95)
                dt = 16'd1;
            else
                dt = '1;
            send_sample(pos, dt);
        end
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] center;
        int unsigned left, run_len;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values with only the rate gain set: the first sample has no
        // position change, later ones hit the reset limit of 255
        write_reg(REG_GAIN_DERIV, 32'h0100_0000);
        cfg_we <= 1'b0;
        send_sample(32'd1000, '0);
        send_sample(32'd1001, 16'd1);
        send_sample(32'd1000, '0);
        send_sample(32'h7FFF_FFFF, '1);
        s_tvalid <= 1'b0;
        wait_drained();

        // Unit gains, position extremes and a truncated rate
        load_settings('0, 32'h0001_0000, 32'h0001_0000, '0, 8'd255);
        send_sample(32'd100, 16'd1);
        send_sample(32'd50, 16'd7);
        send_sample(-32'sd100, '0);
        send_sample(32'd300, 16'd1);
        send_sample(32'h8000_0000, '1);
        send_sample(32'h7FFF_FFFF, 16'd1);
        send_sample('1, 16'd3);
        s_tvalid <= 1'b0;
        wait_drained();

        // Zero limit with extreme gains and target
        load_settings(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_sample(32'h7FFF_FFFF, 16'd1);
        send_sample('0, 16'd5);
        send_sample(32'h8000_0000, '0);
        s_tvalid <= 1'b0;
        wait_drained();

        // Half gain: fractional sums truncate toward zero on both signs
        load_settings('0, 32'h0000_8000, '0, '0, 8'd200);
        send_sample(32'd3, 16'd1);
        send_sample(-32'sd3, 16'd1);
        send_sample(32'd1, 16'd1);
        send_sample(-32'sd1, 16'd1);
        s_tvalid <= 1'b0;
        wait_drained();

        // Integral build-up with a small integral gain
        load_settings(32'd1000, '0, '0, 32'h0000_0100, 8'd255);
        repeat (5)
            send_sample('0, 16'($urandom_range(1, 65535)));
        s_tvalid <= 1'b0;
        wait_drained();

        // Random runs, each under a fresh register setting
        left = RANDOM_ITEMS;
        while (left > 0) begin
            if (left <= FINAL_RUN) begin
                idle_on = 1'b0;
                run_len = left;
            end else begin
                run_len = $urandom_range(60, 200);
                if (run_len > left - FINAL_RUN)
                    run_len = left - FINAL_RUN;
            end
            load_random_settings(center);
            send_random_run(run_len, center);
            left -= run_len;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Sent %0d samples under %0d register settings; %0d results checked, %0d clamped.",
                 samples_sent, settings_loaded, tracker.checked, tracker.clamped_seen);
        $display("Result side held off once for %0d cycles to back up the sample stream.",
                 HOLD_CYCLES);
        if (tracker.mismatches == 0 && tracker.pending_drives.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Timeout at %0t with %0d results outstanding",
                 $time, tracker.pending_drives.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== pid_position_motor_drive.f =====
rtl/pidm_pkg.sv
rtl/pidm_muldiv.sv
rtl/pid_position_motor_drive.sv
tb/tb.sv
